[hdl/clwu_pkg.sv]
// Package: shared types and constants for the winner-take-all learning block.
`default_nettype none
package clwu_pkg;

  localparam int NEURONS_DEFAULT = 64;
  localparam int DIMS_DEFAULT    = 8;

  localparam logic [15:0] LEARNING_RATE_RESET = 16'd32768;
  localparam logic [34:0] DIST_MAX            = 35'h7_FFFF_FFFF;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_WINNER = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         neuron_index;
    logic [2:0]         dim_index;
    logic signed [15:0] value;
    logic               last;
  } req_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] read_value;
    logic [5:0]         winner_index;
    logic [34:0]        min_distance_sq;
  } res_t;

endpackage
`default_nettype wire

[hdl/clwu_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module clwu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/clwu_unit.sv]
// Shared arithmetic unit: difference, then one multiplier that squares or scales it.
`default_nettype none
module clwu_unit (
  input  wire logic               clk,
  input  wire logic               square,
  input  wire logic signed [15:0] sample,
  input  wire logic signed [15:0] weight,
  input  wire logic [15:0]        learning_rate,
  output logic signed [33:0]      prod,
  output logic signed [15:0]      weight_out
);

  logic signed [16:0] diff;
  logic signed [15:0] weight_d;
  logic               square_d;
  logic signed [16:0] mult_b;

  // The same multiplier serves the distance search and the weight update.
  assign mult_b = square_d ? diff : $signed({1'b0, learning_rate});

  always_ff @(posedge clk) begin
    diff       <= {sample[15], sample} - {weight[15], weight};
    weight_d   <= weight;
    square_d   <= square;
    prod       <= 34'(diff) * 34'(mult_b);
    weight_out <= weight_d;
  end

endmodule
`default_nettype wire

[hdl/competitive_learning_winner_update_top.sv]
// Top level: command decode, sequencer, search and update of the weight memory.
`default_nettype none
// A request is taken when start is high and busy is low. A weight write or a sample
// element without last leaves the block idle. A weight read gives one result on
// done. A sample element with last runs the search and update; the search reads
// every weight through the single read port of the weight memory, and both use the
// one shared multiplier. The winner report appears on done at the end. Every result
// is valid for exactly one cycle with done high and cannot be held off, so the
// receiver must take it then. The learning rate may be written at any time the block
// is idle and takes effect on the next sample.
module competitive_learning_winner_update_top #(
  parameter int NEURONS = clwu_pkg::NEURONS_DEFAULT,
  parameter int DIMS    = clwu_pkg::DIMS_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire clwu_pkg::req_t req,
  output logic                done,
  output clwu_pkg::res_t      result,
  input  wire logic           cfg_wr_en,
  input  wire logic [15:0]    cfg_wr_data
);

  localparam int NEU_W  = $clog2(NEURONS);
  localparam int DIM_W  = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int ADDR_W = NEU_W + DIM_W;
  localparam int ACC_W  = 32 + DIM_W;
  localparam int CMP_W  = (ACC_W > 35) ? ACC_W : 35;
  localparam logic [NEU_W-1:0] LAST_N = NEU_W'(NEURONS - 1);
  localparam logic [DIM_W-1:0] LAST_D = DIM_W'(DIMS - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_SEARCH = 6'b000100,
    S_SDRAIN = 6'b001000,
    S_UPDATE = 6'b010000,
    S_UDRAIN = 6'b100000
  } state_t;

  state_t state;
  logic [15:0] learning_rate;

  logic accept;
  logic in_range;
  logic read_ok;

  logic [NEU_W-1:0] cnt_n;
  logic [DIM_W-1:0] cnt_d;

  // Pipeline tags: stage 1 is the memory read, 2 the difference, 3 the product.
  logic             v1, v2, v3;
  logic [NEU_W-1:0] n1, n2, n3;
  logic [DIM_W-1:0] d1, d2, d3;
  logic             f1, f2, f3;
  logic             l1, l2, l3;
  logic             u1, u2, u3;

  logic             iss_v;
  logic             iss_u;
  logic [NEU_W-1:0] iss_n;

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_sum;
  logic [ACC_W-1:0] best;
  logic [NEU_W-1:0] best_n;

  logic              w_we;
  logic [ADDR_W-1:0] w_waddr;
  logic [15:0]       w_wdata;
  logic [ADDR_W-1:0] w_raddr;
  logic [15:0]       w_rdata;
  logic              s_we;
  logic [DIM_W-1:0]  s_raddr;
  logic [15:0]       s_rdata;

  logic signed [33:0] prod;
  logic signed [15:0] weight_out;
  logic signed [17:0] delta;
  logic signed [18:0] upd_sum;
  logic signed [15:0] upd_value;
  logic [34:0]        dist_report;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(req.neuron_index) < NEURONS) && (32'(req.dim_index) < DIMS);

  assign iss_v = (state == S_SEARCH) || (state == S_UPDATE);
  assign iss_u = (state == S_UPDATE);
  assign iss_n = iss_u ? best_n : cnt_n;

  // Weight memory: update write-back has the port while the block is busy.
  assign w_we    = (v3 && u3) || (accept && req.opcode == clwu_pkg::OP_WRITE && in_range);
  assign w_waddr = (v3 && u3) ? {best_n, d3}
                              : {NEU_W'(req.neuron_index), DIM_W'(req.dim_index)};
  assign w_wdata = (v3 && u3) ? upd_value : req.value;
  assign w_raddr = iss_v ? {iss_n, cnt_d}
                         : {NEU_W'(req.neuron_index), DIM_W'(req.dim_index)};

  assign s_we    = accept && req.opcode == clwu_pkg::OP_SAMPLE
                   && (32'(req.dim_index) < DIMS);
  assign s_raddr = cnt_d;

  clwu_ram #(
    .WIDTH (16),
    .DEPTH (NEURONS << DIM_W)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  clwu_ram #(
    .WIDTH (16),
    .DEPTH (1 << DIM_W)
  ) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (DIM_W'(req.dim_index)),
    .wdata (req.value),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  clwu_unit u_unit (
    .clk           (clk),
    .square        (!u1),
    .sample        (s_rdata),
    .weight        (w_rdata),
    .learning_rate (learning_rate),
    .prod          (prod),
    .weight_out    (weight_out)
  );

  // Distance accumulation; squares are below 2^32.
  assign acc_sum = f3 ? ACC_W'(prod[31:0]) : acc + ACC_W'(prod[31:0]);

  // Update: arithmetic shift floors the scaled step, then saturate to 16 bits.
  assign delta   = prod[33:16];
  assign upd_sum = {{3{weight_out[15]}}, weight_out} + {delta[17], delta};
  always_comb begin
    if (upd_sum > 19'sd32767) begin
      upd_value = 16'sh7FFF;
    end else if (upd_sum < -19'sd32768) begin
      upd_value = -16'sh8000;
    end else begin
      upd_value = upd_sum[15:0];
    end
  end

  assign dist_report = (CMP_W'(best) > CMP_W'(clwu_pkg::DIST_MAX)) ? clwu_pkg::DIST_MAX
                                                                    : 35'(best);

  always_ff @(posedge clk) begin
    n1 <= iss_n;     n2 <= n1; n3 <= n2;
    d1 <= cnt_d;     d2 <= d1; d3 <= d2;
    f1 <= (cnt_d == '0); f2 <= f1; f3 <= f2;
    l1 <= (cnt_d == LAST_D); l2 <= l1; l3 <= l2;
    u1 <= iss_u;     u2 <= u1; u3 <= u2;
    if (accept) begin
      read_ok <= in_range;
    end
    if (v3 && !u3) begin
      acc <= acc_sum;
      if (l3 && (n3 == '0 || acc_sum < best)) begin
        best   <= acc_sum;
        best_n <= n3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      learning_rate <= clwu_pkg::LEARNING_RATE_RESET;
      cnt_n         <= '0;
      cnt_d         <= '0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      done          <= 1'b0;
      result        <= '0;
    end else begin
      v1   <= iss_v;
      v2   <= v1;
      v3   <= v2;
      done <= 1'b0;
      if (cfg_wr_en) begin
        learning_rate <= cfg_wr_data;
      end
      unique case (state)
        S_IDLE: begin
          cnt_n <= '0;
          cnt_d <= '0;
          if (accept) begin
            if (req.opcode == clwu_pkg::OP_READ) begin
              state <= S_READ;
            end else if (req.opcode == clwu_pkg::OP_SAMPLE && req.last) begin
              state <= S_SEARCH;
            end
          end
        end
        S_READ: begin
          done                   <= 1'b1;
          result.result_kind     <= clwu_pkg::KIND_READ;
          result.read_value      <= read_ok ? w_rdata : '0;
          result.winner_index    <= '0;
          result.min_distance_sq <= '0;
          state                  <= S_IDLE;
        end
        S_SEARCH: begin
          if (cnt_d == LAST_D) begin
            cnt_d <= '0;
            if (cnt_n == LAST_N) begin
              state <= S_SDRAIN;
            end else begin
              cnt_n <= cnt_n + 1'b1;
            end
          end else begin
            cnt_d <= cnt_d + 1'b1;
          end
        end
        S_SDRAIN: begin
          if (!(v1 || v2 || v3)) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (cnt_d == LAST_D) begin
            cnt_d <= '0;
            state <= S_UDRAIN;
          end else begin
            cnt_d <= cnt_d + 1'b1;
          end
        end
        S_UDRAIN: begin
          if (!(v1 || v2 || v3)) begin
            done                   <= 1'b1;
            result.result_kind     <= clwu_pkg::KIND_WINNER;
            result.read_value      <= '0;
            result.winner_index    <= 6'(best_n);
            result.min_distance_sq <= dist_report;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[sim/tb_competitive_learning_winner_update_top.sv]
// Testbench for the winner-take-all learning block: directed and random requests, self-checked.
`default_nettype none
module tb_competitive_learning_winner_update_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_NEURONS = clwu_pkg::NEURONS_DEFAULT;
  localparam int N_DIMS = clwu_pkg::DIMS_DEFAULT;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // A search visits every weight once through one read port, plus a short tail.
  localparam int SEARCH_CYCLES = N_NEURONS * N_DIMS + N_DIMS + 9;
  localparam int WATCHDOG_LIMIT = 8 * (SEARCH_CYCLES + 64);
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS = 155;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  clwu_pkg::req_t req = '0;
  logic done;
  clwu_pkg::res_t result;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  competitive_learning_winner_update_top #(
    .NEURONS(N_NEURONS),
    .DIMS(N_DIMS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .result(result),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  clwu_pkg::req_t pending_requests[$];
  clwu_pkg::res_t expected_results[$];

  // Shadow copy of the block's state.
  logic signed [15:0] weight_model [N_NEURONS*N_DIMS];
  logic signed [15:0] sample_model [N_DIMS];
  logic [15:0] rate_model = clwu_pkg::LEARNING_RATE_RESET;
  logic signed [15:0] preload [N_NEURONS*N_DIMS];

  int n_queued = 0;
  int n_accepted = 0;
  int n_read_results = 0;
  int n_winner_reports = 0;
  int n_rate_writes = 0;
  int n_errors = 0;
  int quiet_cycles = 0;
  int burst_left = 1;
  int gap_left = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  // Applies one accepted request to the shadow state and queues its result, if any.
  task automatic apply_request(input clwu_pkg::req_t r);
    clwu_pkg::res_t e;
    int best, idx, w, upd;
    longint best_d, dist_acc, diff, step;
    e = '0;
    idx = int'(r.neuron_index) * N_DIMS + int'(r.dim_index);
    case (r.opcode)
      clwu_pkg::OP_WRITE: begin
        if (r.neuron_index < N_NEURONS && r.dim_index < N_DIMS) weight_model[idx] = r.value;
      end
      clwu_pkg::OP_READ: begin
        e.result_kind = clwu_pkg::KIND_READ;
        if (r.neuron_index < N_NEURONS && r.dim_index < N_DIMS) e.read_value = weight_model[idx];
        expected_results.insert(expected_results.size(), e);
      end
      clwu_pkg::OP_SAMPLE: begin
        if (r.dim_index < N_DIMS) sample_model[r.dim_index] = r.value;
        if (r.last) begin
          best = 0;
          best_d = 0;
          for (int n = 0; n < N_NEURONS; n++) begin
            dist_acc = 0;
            for (int d = 0; d < N_DIMS; d++) begin
              diff = longint'(sample_model[d]) - longint'(weight_model[n*N_DIMS + d]);
              dist_acc += diff * diff;
            end
            // Strict compare keeps the lowest index on a tie.
            if (n == 0 || dist_acc < best_d) begin
              best_d = dist_acc;
              best = n;
            end
          end
          for (int d = 0; d < N_DIMS; d++) begin
            w = int'(weight_model[best*N_DIMS + d]);
            step = longint'(rate_model) * longint'(int'(sample_model[d]) - w);
            upd = w + int'(step >>> 16);
            if (upd > 32767) upd = 32767;
            if (upd < -32768) upd = -32768;
            weight_model[best*N_DIMS + d] = 16'(upd);
          end
          e.result_kind = clwu_pkg::KIND_WINNER;
          e.winner_index = 6'(best);
          e.min_distance_sq = (best_d > longint'(clwu_pkg::DIST_MAX)) ? clwu_pkg::DIST_MAX
                                                                      : 35'(best_d);
          expected_results.insert(expected_results.size(), e);
        end
      end
      default: ;
    endcase
  endtask

  // Sender: bursts of random length separated by random gaps, some long bursts with no gap.
  always @(posedge clk) begin : drive_requests
    clwu_pkg::req_t nxt_req;
    logic nxt_start;
    nxt_req = req;
    nxt_start = start;
    if (rst) begin
      nxt_start = 1'b0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left--;
        nxt_start = 1'b0;
      end else if (pending_requests.size() > 0) begin
        nxt_req = pending_requests.pop_front();
        nxt_start = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(40, 120);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = $urandom_range(1, 8);
          end
        end
      end else begin
        nxt_start = 1'b0;
      end
    end
    start <= nxt_start;
    req <= nxt_req;
  end

  // Results are checked before the request taken at the same edge is predicted.
  always @(posedge clk) begin : observe
    clwu_pkg::res_t want;
    if (!rst) begin
      if (done) begin
        if (result.result_kind === clwu_pkg::KIND_WINNER) n_winner_reports++;
        else n_read_results++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: kind %0b winner %0d",
                                    result.result_kind, result.winner_index));
        end else begin
          want = expected_results.pop_front();
          if (result.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind got %0b want %0b",
                                      result.result_kind, want.result_kind));
          if (result.read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %0d want %0d",
                                      result.read_value, want.read_value));
          if (result.winner_index !== want.winner_index)
            report_mismatch($sformatf("winner_index got %0d want %0d",
                                      result.winner_index, want.winner_index));
          if (result.min_distance_sq !== want.min_distance_sq)
            report_mismatch($sformatf("min_distance_sq got %0d want %0d",
                                      result.min_distance_sq, want.min_distance_sq));
        end
      end
      if (start && !busy) begin
        n_accepted++;
        apply_request(req);
      end
      if (cfg_wr_en) begin
        rate_model = cfg_wr_data;
        n_rate_writes++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: nothing accepted for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_req(input logic [1:0] op, input int n, input int d,
                          input logic signed [15:0] v, input bit lst);
    clwu_pkg::req_t r;
    r.opcode = op;
    r.neuron_index = 6'(n);
    r.dim_index = 3'(d);
    r.value = v;
    r.last = lst;
    pending_requests.insert(pending_requests.size(), r);
    n_queued++;
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3, 4: return 16'($urandom_range(0, 4095) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly complete samples in shuffled element order; the rest is weight traffic,
  // partial or oddly terminated samples and unused opcodes.
  task automatic queue_random_phase(input int n_items);
    int made, pick, k, j, tmp;
    int order [N_DIMS];
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        for (int i = 0; i < N_DIMS; i++) order[i] = i;
        for (int i = N_DIMS - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < N_DIMS; i++)
          push_req(clwu_pkg::OP_SAMPLE, $urandom, order[i], pick_value(), i == N_DIMS - 1);
        made += N_DIMS;
      end else if (pick < 63) begin
        k = $urandom_range(1, N_DIMS - 1);
        for (int i = 0; i < k; i++)
          push_req(clwu_pkg::OP_SAMPLE, $urandom, $urandom_range(0, N_DIMS - 1), pick_value(),
                   (i == k - 1) ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 5) == 0));
        made += k;
      end else if (pick < 78) begin
        push_req(clwu_pkg::OP_WRITE, $urandom, $urandom, pick_value(),
                 bit'($urandom_range(0, 1)));
        made++;
      end else if (pick < 93) begin
        push_req(clwu_pkg::OP_READ, $urandom, $urandom, 16'($urandom),
                 bit'($urandom_range(0, 1)));
        made++;
      end else if (pick < 97) begin
        push_req(clwu_pkg::OP_SAMPLE, $urandom, $urandom, pick_value(),
                 bit'($urandom_range(0, 1)));
        made++;
      end else begin
        push_req(OP_UNUSED, $urandom, $urandom, 16'($urandom), bit'($urandom_range(0, 1)));
        made++;
      end
    end
  endtask

  // The learning rate may only change once the block has gone quiet.
  task automatic wait_drained();
    while (n_accepted != n_queued || expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_rate(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] rates [RANDOM_PHASES];
    rates = '{16'd65535, 16'd1, 16'd0, 16'd32768, 16'd0, 16'd0, 16'd4096};
    rates[4] = 16'($urandom);
    rates[5] = 16'($urandom);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every weight is loaded before anything reads it. Neuron 0 sits at the top of
    // the range, the last neuron at the bottom, and neuron 20 copies neuron 7.
    for (int i = 0; i < N_NEURONS * N_DIMS; i++) preload[i] = pick_value();
    for (int d = 0; d < N_DIMS; d++) begin
      preload[d] = 16'sh7FFF;
      preload[(N_NEURONS - 1) * N_DIMS + d] = 16'sh8000;
      preload[20 * N_DIMS + d] = preload[7 * N_DIMS + d];
    end
    for (int n = 0; n < N_NEURONS; n++)
      for (int d = 0; d < N_DIMS; d++)
        push_req(clwu_pkg::OP_WRITE, n, d, preload[n * N_DIMS + d], 1'b0);

    // Directed part, run at the reset learning rate.
    push_req(clwu_pkg::OP_READ, 0, 0, 16'sh0000, 1'b0);
    push_req(clwu_pkg::OP_READ, N_NEURONS - 1, N_DIMS - 1, 16'shFFFF, 1'b0);
    push_req(OP_UNUSED, 63, 7, 16'sh7FFF, 1'b1);
    push_req(clwu_pkg::OP_WRITE, 3, 2, 16'sh0000, 1'b1);
    push_req(clwu_pkg::OP_READ, 3, 2, 16'sh8000, 1'b1);
    // Sample equal to two neurons: the lower index must win at zero distance.
    for (int d = 0; d < N_DIMS; d++)
      push_req(clwu_pkg::OP_SAMPLE, 63, d, preload[7 * N_DIMS + d], d == N_DIMS - 1);
    for (int d = 0; d < N_DIMS; d++)
      push_req(clwu_pkg::OP_SAMPLE, 0, d, 16'sh8000, d == N_DIMS - 1);
    // A single element with last reuses the rest of the buffered sample.
    push_req(clwu_pkg::OP_SAMPLE, 0, 0, 16'sh7FFF, 1'b1);
    push_req(clwu_pkg::OP_READ, N_NEURONS - 1, 0, 16'sh0000, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      write_rate(rates[p]);
      queue_random_phase(PHASE_ITEMS);
    end

    while (n_accepted != n_queued || expected_results.size() != 0) @(negedge clk);
    repeat (SEARCH_CYCLES + 50) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("Covered %0d requests with %0d read results and %0d winner reports,",
             n_accepted, n_read_results, n_winner_reports);
    $display("across the reset learning rate and %0d written rates.", n_rate_writes);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

[competitive_learning_winner_update_top.f]
hdl/clwu_pkg.sv
hdl/clwu_ram.sv
hdl/clwu_unit.sv
hdl/competitive_learning_winner_update_top.sv
sim/tb_competitive_learning_winner_update_top.sv
